[hw/rtl/serial_frame_deframer_defines.svh]
// assertion macros for the serial frame deframer
`ifndef SERIAL_FRAME_DEFRAMER_DEFINES_SVH
`define SERIAL_FRAME_DEFRAMER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define SFD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define SFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SFD_ASSERT_NOW(label, clk, rst, ante, cons)
`define SFD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[hw/rtl/sfd_pkg.sv]
// shared types and constants of the serial frame deframer
package sfd_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_FIRST  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_SECOND = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LENGTH   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_TICKS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DATA_TICKS   = 3'd4;

   localparam logic [7:0]  RST_START_FIRST  = 8'hAA;
   localparam logic [7:0]  RST_START_SECOND = 8'h55;
   localparam logic [15:0] RST_MAX_LENGTH   = 16'd1024;
   localparam logic [7:0]  RST_HEADER_TICKS = 8'd2;
   localparam logic [7:0]  RST_DATA_TICKS   = 8'd20;

   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BAD_LEN = 2'd1;
   localparam logic [1:0] ST_CKSUM   = 2'd2;
   localparam logic [1:0] ST_TIMEOUT = 2'd3;

   typedef struct packed {
      logic       func;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  payload_byte;
      logic [1:0]  status;
      logic [15:0] frame_length;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  start_mark_first;
      logic [7:0]  start_mark_second;
      logic [15:0] max_payload_length;
      logic [7:0]  header_tick_limit;
      logic [7:0]  data_tick_limit;
   } cfg_type;

   // one queue entry: an optional payload byte and an optional frame end
   typedef struct packed {
      logic        has_byte;
      logic        has_end;
      logic [7:0]  byte_val;
      logic [1:0]  status;
      logic [15:0] frame_length;
   } act_type;

endpackage

[hw/rtl/sfd_front.sv]
// front end: frame parser that turns payload bytes and frame ends into queue entries
module sfd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sfd_pkg::req_type req,
   input  sfd_pkg::cfg_type cfg,
   input  logic             q_full,
   output logic             q_push,
   output sfd_pkg::act_type q_act
);

   localparam logic [1:0] PH_HUNT = 2'd0;
   localparam logic [1:0] PH_HEAD = 2'd1;
   localparam logic [1:0] PH_DATA = 2'd2;

   localparam logic [2:0] HDR_LEN_HI = 3'd0;
   localparam logic [2:0] HDR_LEN_LO = 3'd1;
   localparam logic [2:0] HDR_CHK    = 3'd3;
   localparam logic [2:0] HDR_SUM_HI = 3'd4;
   localparam logic [2:0] HDR_SUM_LO = 3'd5;

   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[16] ? (s[15:0] + 16'd1) : s[15:0];
   endfunction

   logic [1:0]  phase_ff, phase_in;
   logic        saw_first_ff, saw_first_in;
   logic [2:0]  hdr_pos_ff, hdr_pos_in;
   logic [15:0] decl_len_ff, decl_len_in;
   logic [7:0]  len_chk_ff, len_chk_in;
   logic [15:0] rx_sum_ff, rx_sum_in;
   logic [15:0] taken_ff, taken_in;
   logic [15:0] run_sum_ff, run_sum_in;
   logic [7:0]  pend_ff, pend_in;
   logic [7:0]  ticks_ff, ticks_in;

   logic        accept;
   logic        produce;
   logic [7:0]  b;
   logic [8:0]  tick_next;
   logic [7:0]  limit;
   logic [15:0] taken_next;
   logic        is_final;
   logic [15:0] addend;
   logic [15:0] sum_new;
   logic [15:0] rx_sum_full;
   logic [7:0]  len_xor;

   assign req_ready = ~q_full;
   assign accept    = req_valid & req_ready;
   assign b         = req.rx_byte;

   assign tick_next   = {1'b0, ticks_ff} + 9'd1;
   assign limit       = (phase_ff == PH_HEAD) ? cfg.header_tick_limit : cfg.data_tick_limit;
   assign taken_next  = taken_ff + 16'd1;
   assign is_final    = (taken_next == decl_len_ff);
   assign addend      = taken_ff[0] ? {pend_ff, b} : {8'h00, b};
   assign sum_new     = oc_add(run_sum_ff, addend);
   assign rx_sum_full = {rx_sum_ff[15:8], b};
   assign len_xor     = decl_len_ff[15:8] ^ decl_len_ff[7:0];

   always_comb begin
      phase_in     = phase_ff;
      saw_first_in = saw_first_ff;
      hdr_pos_in   = hdr_pos_ff;
      decl_len_in  = decl_len_ff;
      len_chk_in   = len_chk_ff;
      rx_sum_in    = rx_sum_ff;
      taken_in     = taken_ff;
      run_sum_in   = run_sum_ff;
      pend_in      = pend_ff;
      ticks_in     = ticks_ff;
      produce      = 1'b0;
      q_act        = '0;

      unique case (phase_ff)
         PH_HEAD, PH_DATA: begin
            if (req.func == sfd_pkg::FUNC_TICK) begin
               if (tick_next > {1'b0, limit}) begin
                  produce            = 1'b1;
                  q_act.has_end      = 1'b1;
                  q_act.status       = sfd_pkg::ST_TIMEOUT;
                  q_act.frame_length = (phase_ff == PH_DATA) ? decl_len_ff : 16'd0;
                  phase_in           = PH_HUNT;
                  ticks_in           = 8'd0;
               end else begin
                  ticks_in = tick_next[7:0];
               end
            end else if (phase_ff == PH_HEAD) begin
               unique case (hdr_pos_ff)
                  HDR_LEN_HI: decl_len_in = {b, decl_len_ff[7:0]};
                  HDR_LEN_LO: decl_len_in = {decl_len_ff[15:8], b};
                  HDR_CHK:    len_chk_in  = b;
                  HDR_SUM_HI: rx_sum_in   = {b, rx_sum_ff[7:0]};
                  HDR_SUM_LO: rx_sum_in   = rx_sum_full;
                  default: ;
               endcase
               if (hdr_pos_ff < HDR_SUM_LO) begin
                  hdr_pos_in = hdr_pos_ff + 3'd1;
               end else begin
                  hdr_pos_in = 3'd0;
                  if (len_chk_ff != len_xor || decl_len_ff > cfg.max_payload_length) begin
                     produce            = 1'b1;
                     q_act.has_end      = 1'b1;
                     q_act.status       = sfd_pkg::ST_BAD_LEN;
                     q_act.frame_length = decl_len_ff;
                     phase_in           = PH_HUNT;
                  end else if (decl_len_ff == 16'd0) begin
                     produce       = 1'b1;
                     q_act.has_end = 1'b1;
                     q_act.status  = (rx_sum_full == 16'd0) ? sfd_pkg::ST_OK
                                                            : sfd_pkg::ST_CKSUM;
                     phase_in      = PH_HUNT;
                  end else begin
                     phase_in   = PH_DATA;
                     ticks_in   = 8'd0;
                     taken_in   = 16'd0;
                     run_sum_in = 16'd0;
                     pend_in    = 8'd0;
                  end
               end
            end else begin
               produce        = 1'b1;
               q_act.has_byte = 1'b1;
               q_act.byte_val = b;
               taken_in       = taken_next;
               if (!taken_ff[0]) begin
                  pend_in = b;
               end
               if (taken_ff[0] || is_final) begin
                  run_sum_in = sum_new;
               end
               if (is_final) begin
                  q_act.has_end      = 1'b1;
                  q_act.status       = (~sum_new == rx_sum_ff) ? sfd_pkg::ST_OK
                                                               : sfd_pkg::ST_CKSUM;
                  q_act.frame_length = decl_len_ff;
                  phase_in           = PH_HUNT;
                  ticks_in           = 8'd0;
               end
            end
         end
         default: begin
            phase_in = PH_HUNT;
            if (req.func == sfd_pkg::FUNC_BYTE) begin
               if (saw_first_ff && b == cfg.start_mark_second) begin
                  phase_in     = PH_HEAD;
                  saw_first_in = 1'b0;
                  hdr_pos_in   = 3'd0;
                  decl_len_in  = 16'd0;
                  len_chk_in   = 8'd0;
                  rx_sum_in    = 16'd0;
                  ticks_in     = 8'd0;
               end else begin
                  saw_first_in = (b == cfg.start_mark_first);
               end
            end
         end
      endcase
   end

   assign q_push = accept & produce;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         saw_first_ff <= 1'b0;
         hdr_pos_ff   <= 3'd0;
         decl_len_ff  <= 16'd0;
         len_chk_ff   <= 8'd0;
         rx_sum_ff    <= 16'd0;
         taken_ff     <= 16'd0;
         run_sum_ff   <= 16'd0;
         pend_ff      <= 8'd0;
         ticks_ff     <= 8'd0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         saw_first_ff <= saw_first_in;
         hdr_pos_ff   <= hdr_pos_in;
         decl_len_ff  <= decl_len_in;
         len_chk_ff   <= len_chk_in;
         rx_sum_ff    <= rx_sum_in;
         taken_ff     <= taken_in;
         run_sum_ff   <= run_sum_in;
         pend_ff      <= pend_in;
         ticks_ff     <= ticks_in;
      end
   end

endmodule

[hw/rtl/sfd_queue.sv]
// small register queue between parser and result stage
module sfd_queue #(
   parameter int DEPTH = sfd_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sfd_pkg::act_type push_act,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output sfd_pkg::act_type head_act
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sfd_pkg::act_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_act   = entries_ff[rd_ptr_ff];
   assign do_push    = push & ~full;
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_act;
      end
   end

endmodule

[hw/rtl/sfd_back.sv]
// back end: expands queue entries into result items in an output register
module sfd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  sfd_pkg::act_type q_head,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sfd_pkg::rsp_type rsp
);

   logic             rsp_valid_ff, rsp_valid_in;
   sfd_pkg::rsp_type rsp_ff, rsp_in;
   logic             second_ff, second_in;
   logic             can_load;

   assign can_load = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_in       = rsp_ff;
      second_in    = second_ff;
      q_pop        = 1'b0;
      if (q_valid && can_load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         if (q_head.has_byte && !second_ff) begin
            rsp_in.kind         = sfd_pkg::KIND_BYTE;
            rsp_in.payload_byte = q_head.byte_val;
            rsp_in.last         = ~q_head.has_end;
            if (q_head.has_end) begin
               second_in = 1'b1;
            end else begin
               q_pop = 1'b1;
            end
         end else begin
            rsp_in.kind         = sfd_pkg::KIND_END;
            rsp_in.status       = q_head.status;
            rsp_in.frame_length = q_head.frame_length;
            rsp_in.last         = 1'b1;
            second_in           = 1'b0;
            q_pop               = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         second_ff    <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

[hw/rtl/serial_frame_deframer.sv]
// serial frame deframer top level: config registers, parser, queue, result stage
// an accepted item's queue entry, if any, is registered in the queue, then expanded into the output register
// throughput: one item per cycle while the queue is not full; req_ready drops when it fills
// a final payload byte gives two results from one queue entry; the queue absorbs the extra result
// reset: synchronous, active high; registers return to defaults, parser hunts, queue empties
`include "serial_frame_deframer_defines.svh"

module serial_frame_deframer #(
   parameter int QUEUE_DEPTH = sfd_pkg::QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  sfd_pkg::req_type                  req,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output sfd_pkg::rsp_type                  rsp,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sfd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sfd_pkg::CSR_DATA_W-1:0]    csr_data
);

   sfd_pkg::cfg_type cfg_ff, cfg_in;
   logic             q_push, q_full, q_pop, q_valid;
   sfd_pkg::act_type q_act, q_head;
   logic             rsp_byte_shown, rsp_end_shown, rsp_byte_clean;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            sfd_pkg::CSR_START_FIRST:  cfg_in.start_mark_first   = csr_data[7:0];
            sfd_pkg::CSR_START_SECOND: cfg_in.start_mark_second  = csr_data[7:0];
            sfd_pkg::CSR_MAX_LENGTH:   cfg_in.max_payload_length = csr_data;
            sfd_pkg::CSR_HEADER_TICKS: cfg_in.header_tick_limit  = csr_data[7:0];
            sfd_pkg::CSR_DATA_TICKS:   cfg_in.data_tick_limit    = csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_mark_first   <= sfd_pkg::RST_START_FIRST;
         cfg_ff.start_mark_second  <= sfd_pkg::RST_START_SECOND;
         cfg_ff.max_payload_length <= sfd_pkg::RST_MAX_LENGTH;
         cfg_ff.header_tick_limit  <= sfd_pkg::RST_HEADER_TICKS;
         cfg_ff.data_tick_limit    <= sfd_pkg::RST_DATA_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sfd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .cfg       (cfg_ff),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_act     (q_act)
   );

   sfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_act   (q_act),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_act   (q_head)
   );

   sfd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_byte_shown = rsp_valid && rsp.kind == sfd_pkg::KIND_BYTE;
   assign rsp_end_shown  = rsp_valid && rsp.kind == sfd_pkg::KIND_END;
   assign rsp_byte_clean = rsp.status == sfd_pkg::ST_OK && rsp.frame_length == 16'd0;

   `SFD_ASSERT_NOW(a_no_push_when_full, clock, reset, q_push, !q_full)
   `SFD_ASSERT_NOW(a_end_is_last, clock, reset, rsp_end_shown, rsp.last)
   `SFD_ASSERT_NOW(a_byte_clean, clock, reset, rsp_byte_shown, rsp_byte_clean)
   `SFD_ASSERT_NEXT(a_split_follows, clock, reset, rsp_byte_shown && rsp_ready && !rsp.last, rsp_end_shown)

endmodule

[bench/frame_checker.sv]
// checker for the serial frame deframer: tracks the parser, predicts result items, compares them
module frame_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  sfd_pkg::req_type                  req,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  sfd_pkg::rsp_type                  rsp,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [sfd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sfd_pkg::CSR_DATA_W-1:0]    csr_data,
   output int                                mismatches,
   output int                                awaited,
   output int                                results_checked
);
   import sfd_pkg::*;

   typedef enum logic [1:0] {PH_HUNT, PH_HEADER, PH_PAYLOAD} parse_phase_type;

   logic [7:0]      cfg_first, cfg_second, cfg_header_ticks, cfg_data_ticks;
   logic [15:0]     cfg_max_length;

   parse_phase_type phase;
   logic            armed;
   logic [2:0]      header_pos;
   logic [15:0]     declared_len, frame_cksum, byte_count, pair_sum;
   logic [7:0]      len_check, high_byte, tick_count;

   rsp_type         frame_results [$];
   rsp_type         want;

   function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + s[16];
   endfunction

   task automatic expect_result(input logic kind, input logic [7:0] data, input logic [1:0] st,
                                input logic [15:0] len, input logic last);
      rsp_type r;
      r.kind = kind;
      r.payload_byte = data;
      r.status = st;
      r.frame_length = len;
      r.last = last;
      frame_results.push_back(r);
   endtask

   task automatic parse_item(input req_type item);
      logic [8:0]  next_ticks;
      logic [7:0]  limit;
      logic [15:0] calc;
      if (phase == PH_HUNT) begin
         if (item.func == FUNC_BYTE) begin
            if (armed && item.rx_byte == cfg_second) begin
               phase = PH_HEADER;
               armed = 1'b0;
               header_pos = '0;
               declared_len = '0;
               len_check = '0;
               frame_cksum = '0;
               tick_count = '0;
            end else begin
               armed = (item.rx_byte == cfg_first);
            end
         end
      end else if (item.func == FUNC_TICK) begin
         next_ticks = tick_count + 9'd1;
         limit = (phase == PH_HEADER) ? cfg_header_ticks : cfg_data_ticks;
         if (next_ticks > limit) begin
            expect_result(KIND_END, 8'd0, ST_TIMEOUT,
                          (phase == PH_PAYLOAD) ? declared_len : 16'd0, 1'b1);
            phase = PH_HUNT;
            tick_count = '0;
         end else begin
            tick_count = next_ticks[7:0];
         end
      end else if (phase == PH_HEADER) begin
         case (header_pos)
            3'd0: declared_len[15:8] = item.rx_byte;
            3'd1: declared_len[7:0] = item.rx_byte;
            3'd2: ;
            3'd3: len_check = item.rx_byte;
            3'd4: frame_cksum[15:8] = item.rx_byte;
            default: frame_cksum[7:0] = item.rx_byte;
         endcase
         if (header_pos < 3'd5) begin
            header_pos = header_pos + 3'd1;
         end else begin
            header_pos = '0;
            if (len_check != (declared_len[15:8] ^ declared_len[7:0])
                || declared_len > cfg_max_length) begin
               expect_result(KIND_END, 8'd0, ST_BAD_LEN, declared_len, 1'b1);
               phase = PH_HUNT;
            end else if (declared_len == 16'd0) begin
               expect_result(KIND_END, 8'd0, (frame_cksum == 16'd0) ? ST_OK : ST_CKSUM,
                             16'd0, 1'b1);
               phase = PH_HUNT;
            end else begin
               phase = PH_PAYLOAD;
               tick_count = '0;
               byte_count = '0;
               pair_sum = '0;
               high_byte = '0;
            end
         end
      end else begin
         if (!byte_count[0]) high_byte = item.rx_byte;
         else pair_sum = fold_add(pair_sum, {high_byte, item.rx_byte});
         byte_count = byte_count + 16'd1;
         if (byte_count != declared_len) begin
            expect_result(KIND_BYTE, item.rx_byte, ST_OK, 16'd0, 1'b1);
         end else begin
            // odd tail byte goes in unshifted
            if (byte_count[0]) pair_sum = fold_add(pair_sum, {8'h00, high_byte});
            calc = ~pair_sum;
            expect_result(KIND_BYTE, item.rx_byte, ST_OK, 16'd0, 1'b0);
            expect_result(KIND_END, 8'd0, (calc == frame_cksum) ? ST_OK : ST_CKSUM,
                          declared_len, 1'b1);
            phase = PH_HUNT;
            tick_count = '0;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_first = RST_START_FIRST;
         cfg_second = RST_START_SECOND;
         cfg_max_length = RST_MAX_LENGTH;
         cfg_header_ticks = RST_HEADER_TICKS;
         cfg_data_ticks = RST_DATA_TICKS;
         phase = PH_HUNT;
         armed = 1'b0;
         header_pos = '0;
         declared_len = '0;
         len_check = '0;
         frame_cksum = '0;
         byte_count = '0;
         pair_sum = '0;
         high_byte = '0;
         tick_count = '0;
         frame_results.delete();
         mismatches = 0;
         results_checked = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (frame_results.size() == 0) begin
               $error("result item with nothing expected: kind %0d byte %0h status %0d",
                      rsp.kind, rsp.payload_byte, rsp.status);
               mismatches++;
            end else begin
               want = frame_results.pop_front();
               results_checked++;
               if (rsp.kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, rsp.kind);
                  mismatches++;
               end
               if (rsp.payload_byte !== want.payload_byte) begin
                  $error("payload_byte: expected %0h, got %0h",
                         want.payload_byte, rsp.payload_byte);
                  mismatches++;
               end
               if (rsp.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp.status);
                  mismatches++;
               end
               if (rsp.frame_length !== want.frame_length) begin
                  $error("frame_length: expected %0d, got %0d",
                         want.frame_length, rsp.frame_length);
                  mismatches++;
               end
               if (rsp.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp.last);
                  mismatches++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_START_FIRST:  cfg_first = csr_data[7:0];
               CSR_START_SECOND: cfg_second = csr_data[7:0];
               CSR_MAX_LENGTH:   cfg_max_length = csr_data;
               CSR_HEADER_TICKS: cfg_header_ticks = csr_data[7:0];
               CSR_DATA_TICKS:   cfg_data_ticks = csr_data[7:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) parse_item(req);
      end
      awaited = frame_results.size();
   end

endmodule

[bench/testbench.sv]
// top of the serial frame deframer bench: clock, reset, frame stimulus, register settings, verdict
module testbench;
   import sfd_pkg::*;

   localparam int ITEMS_PER_SETTING = 210;
   localparam int CYCLE_LIMIT = 400000;

   logic                    clock, reset;
   logic                    req_valid, req_ready;
   req_type                 req;
   logic                    rsp_valid, rsp_ready;
   rsp_type                 rsp;
   logic                    csr_valid, csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0]   csr_data;

   int                      mismatches, awaited, results_checked;
   int                      send_gap_pct, recv_gap_pct;
   int                      items_sent, frames_sent, cycles, tick_budget;
   logic [7:0]              mark_first, mark_second, header_limit, data_limit;
   logic [15:0]             max_length;

   serial_frame_deframer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   frame_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req             (req),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp             (rsp),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatches      (mismatches),
      .awaited         (awaited),
      .results_checked (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $error("run exceeded %0d cycles", CYCLE_LIMIT);
         $display("testbench NOT OK");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_gap_pct);
   end

   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + s[16];
   endfunction

   // called at a falling edge; returns at the falling edge after the item is taken
   task automatic send_item(input logic func, input logic [7:0] data);
      req_type item;
      item.func = func;
      item.rx_byte = data;
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_valid <= 1'b1;
      req <= item;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      items_sent++;
   endtask

   // ticks stay within the budget of the current parser phase
   task automatic send_with_ticks(input logic [7:0] data);
      if (tick_budget > 0 && $urandom_range(7) == 0) begin
         send_item(FUNC_TICK, 8'($urandom));
         tick_budget--;
      end
      send_item(FUNC_BYTE, data);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      do @(negedge clock); while (awaited != 0);
      repeat (6) @(negedge clock);
   endtask

   initial begin : stimulus
      int          setting, pick, len, cut, i;
      logic        in_payload;
      logic [7:0]  body [$];
      logic [7:0]  hdr [0:5];
      logic [7:0]  hi;
      logic [15:0] flen, acc, cksum;
      logic [31:0] junk;

      reset = 1'b1;
      req_valid = 1'b0;
      req = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      items_sent = 0;
      frames_sent = 0;
      cycles = 0;
      tick_budget = 0;
      send_gap_pct = 0;
      recv_gap_pct = 0;
      mark_first = RST_START_FIRST;
      mark_second = RST_START_SECOND;
      max_length = RST_MAX_LENGTH;
      header_limit = RST_HEADER_TICKS;
      data_limit = RST_DATA_TICKS;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (setting = 0; setting < 6; setting++) begin
         case (setting / 2)
            0: begin
               send_gap_pct = 6;
               recv_gap_pct = 62;
            end
            1: begin
               send_gap_pct = 62;
               recv_gap_pct = 6;
            end
            default: begin
               send_gap_pct = 0;
               recv_gap_pct = 0;
            end
         endcase

         if (setting == 0) begin
            // tick while hunting, repeated first mark, empty frame with zero checksum
            send_item(FUNC_TICK, 8'h00);
            send_item(FUNC_BYTE, mark_first);
            send_item(FUNC_BYTE, mark_first);
            send_item(FUNC_BYTE, mark_second);
            repeat (6) send_item(FUNC_BYTE, 8'h00);
            // one odd payload byte
            send_item(FUNC_BYTE, mark_first);
            send_item(FUNC_BYTE, mark_second);
            send_item(FUNC_BYTE, 8'h00); send_item(FUNC_BYTE, 8'h01);
            send_item(FUNC_BYTE, 8'hFF); send_item(FUNC_BYTE, 8'h01);
            send_item(FUNC_BYTE, 8'hFF); send_item(FUNC_BYTE, 8'h7F);
            send_item(FUNC_BYTE, 8'h80);
            // empty frame with a nonzero checksum
            send_item(FUNC_BYTE, mark_first);
            send_item(FUNC_BYTE, mark_second);
            repeat (4) send_item(FUNC_BYTE, 8'h00);
            send_item(FUNC_BYTE, 8'h12); send_item(FUNC_BYTE, 8'h34);
         end else begin
            req_valid <= 1'b0;
            wait_idle();
            case (setting)
               1: begin
                  mark_first = 8'h00;
                  mark_second = 8'h00;
                  max_length = 16'h0000;
                  header_limit = 8'h00;
                  data_limit = 8'h00;
               end
               2: begin
                  mark_first = 8'hFF;
                  mark_second = 8'hFF;
                  max_length = 16'hFFFF;
                  header_limit = 8'hFF;
                  data_limit = 8'hFF;
               end
               default: begin
                  mark_first = 8'($urandom);
                  mark_second = 8'($urandom);
                  max_length = ($urandom_range(3) == 0) ? RST_MAX_LENGTH
                                                        : 16'($urandom_range(40, 1));
                  header_limit = 8'($urandom_range(5));
                  data_limit = 8'($urandom_range(8));
               end
            endcase
            junk = $urandom;
            write_reg(CSR_START_FIRST, {junk[7:0], mark_first});
            write_reg(CSR_START_SECOND, {junk[15:8], mark_second});
            write_reg(CSR_MAX_LENGTH, max_length);
            write_reg(CSR_HEADER_TICKS, {junk[23:16], header_limit});
            write_reg(CSR_DATA_TICKS, {junk[31:24], data_limit});
            csr_valid <= 1'b0;
         end

         while (items_sent < (setting + 1) * ITEMS_PER_SETTING) begin
            // good 0-59, bad checksum 60-69, bad length check 70-77,
            // oversized 78-85, timeout 86-93, line noise 94-99
            pick = $urandom_range(99);
            frames_sent++;
            if (pick >= 94) begin
               repeat ($urandom_range(8, 1)) begin
                  junk = $urandom;
                  send_item(junk[8], junk[7:0]);
               end
               continue;
            end

            if (max_length == 16'd0) len = 0;
            else if ($urandom_range(39) == 0)
               len = $urandom_range((max_length > 16'd200) ? 200 : max_length);
            else len = $urandom_range((max_length > 16'd12) ? 12 : max_length);
            if (pick >= 78 && pick < 86 && max_length != 16'hFFFF)
               len = ($urandom_range(3) == 0) ? 65535 : $urandom_range(65535, max_length + 1);
            flen = 16'(len);

            body.delete();
            acc = '0;
            if (flen <= max_length) begin
               for (i = 0; i < len; i++) begin
                  body.push_back(8'($urandom));
                  if (i % 2 == 0) hi = body[i];
                  else acc = ones_add(acc, {hi, body[i]});
               end
               if (len % 2 == 1) acc = ones_add(acc, {8'h00, hi});
            end
            cksum = (len == 0) ? 16'h0000 : ~acc;
            if (pick >= 60 && pick < 70) cksum = cksum ^ (16'h0001 << $urandom_range(15));

            hdr[0] = flen[15:8];
            hdr[1] = flen[7:0];
            hdr[2] = 8'($urandom);
            hdr[3] = flen[15:8] ^ flen[7:0];
            if ((pick >= 70 && pick < 78) || (pick >= 78 && pick < 86 && flen <= max_length))
               hdr[3] = hdr[3] ^ (8'h01 << $urandom_range(7));
            hdr[4] = cksum[15:8];
            hdr[5] = cksum[7:0];

            if ($urandom_range(3) == 0)
               repeat ($urandom_range(2, 1)) send_item(FUNC_TICK, 8'($urandom));
            if (mark_first != mark_second)
               repeat ($urandom_range(3) == 0 ? $urandom_range(2, 1) : 0)
                  send_item(FUNC_BYTE, mark_first);
            send_item(FUNC_BYTE, mark_first);
            send_item(FUNC_BYTE, mark_second);

            tick_budget = int'(header_limit);
            in_payload = (pick >= 86 && len > 0 && $urandom_range(1) == 0);
            cut = (pick >= 86 && !in_payload) ? $urandom_range(5) : 6;
            for (i = 0; i < cut; i++) send_with_ticks(hdr[i]);
            if (cut < 6) begin
               repeat (tick_budget + 1) send_item(FUNC_TICK, 8'($urandom));
               continue;
            end
            if (flen > max_length || hdr[3] != (flen[15:8] ^ flen[7:0]) || len == 0)
               continue;

            tick_budget = int'(data_limit);
            cut = in_payload ? $urandom_range(len - 1) : len;
            for (i = 0; i < cut; i++) send_with_ticks(body[i]);
            if (in_payload) repeat (tick_budget + 1) send_item(FUNC_TICK, 8'($urandom));
         end
      end

      req_valid <= 1'b0;
      wait_idle();
      $display("%0d items sent in %0d frames under six register settings and three idle mixes",
               items_sent, frames_sent);
      $display("%0d result items checked, %0d mismatches", results_checked, mismatches);
      if (mismatches == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
